// ----- rtl/core/adt_pkg.sv -----
`timescale 1ns / 1ps

package adt_pkg;

  localparam int MaxEntries = 20;
  localparam int CountW     = $clog2(MaxEntries + 1);
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int AddrW      = 48;
  localparam int FieldW     = 5;
  localparam int StatusW    = 3;
  localparam int CmpW       = (CountW > FieldW) ? CountW : FieldW;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_ZERO      = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_INVALID   = 3'd5
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [AddrW-1:0] addr;
    logic [FieldW-1:0] idx;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [FieldW-1:0] slot;
    logic [FieldW-1:0] count;
  } result_t;

endpackage

// ----- rtl/core/adt_table.sv -----
`timescale 1ns / 1ps

module adt_table (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  adt_pkg::item_t  item,
  output adt_pkg::result_t res
);

  logic [adt_pkg::AddrW-1:0]  store_r   [adt_pkg::MaxEntries];
  logic [adt_pkg::AddrW-1:0]  store_nxt [adt_pkg::MaxEntries];
  logic [adt_pkg::CountW-1:0] count_r;
  logic [adt_pkg::CountW-1:0] count_nxt;
  logic [adt_pkg::MaxEntries-1:0] match;
  logic                       hit;
  logic [adt_pkg::IdxW-1:0]   hit_idx;
  logic                       full;
  logic                       idx_ok;

  assign full   = (count_r == adt_pkg::CountW'(adt_pkg::MaxEntries));
  assign idx_ok = (adt_pkg::CmpW'(item.idx) < adt_pkg::CmpW'(count_r));

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < adt_pkg::MaxEntries; i++) begin
      match[i] = (adt_pkg::CountW'(i) < count_r) && (store_r[i] == item.addr);
    end
    for (int i = adt_pkg::MaxEntries - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = adt_pkg::IdxW'(i);
      end
    end
  end

  always_comb begin
    store_nxt  = store_r;
    count_nxt  = count_r;
    res.status = adt_pkg::ST_INVALID;
    res.slot   = '0;
    if (item.op == adt_pkg::OP_INSERT) begin
      if (item.addr == '0) begin
        res.status = adt_pkg::ST_ZERO;
      end else if (hit) begin
        res.status = adt_pkg::ST_DUPLICATE;
        res.slot   = adt_pkg::FieldW'(hit_idx);
      end else if (full) begin
        res.status = adt_pkg::ST_FULL;
      end else begin
        res.status = adt_pkg::ST_ADDED;
        res.slot   = adt_pkg::FieldW'(count_r);
        for (int i = 0; i < adt_pkg::MaxEntries; i++) begin
          if (adt_pkg::CountW'(i) == count_r) begin
            store_nxt[i] = item.addr;
          end
        end
        count_nxt = count_r + 1'b1;
      end
    end else if (idx_ok) begin
      // Entries at or above the count are zero, so shifting down clears the vacated slot.
      res.status = adt_pkg::ST_REMOVED;
      res.slot   = item.idx;
      for (int i = 0; i < adt_pkg::MaxEntries - 1; i++) begin
        if (adt_pkg::CmpW'(i) >= adt_pkg::CmpW'(item.idx)) begin
          store_nxt[i] = store_r[i + 1];
        end
      end
      store_nxt[adt_pkg::MaxEntries - 1] = '0;
      count_nxt = count_r - 1'b1;
    end
    res.count = adt_pkg::FieldW'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int i = 0; i < adt_pkg::MaxEntries; i++) begin
        store_r[i] <= '0;
      end
    end else if (en) begin
      count_r <= count_nxt;
      store_r <= store_nxt;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= adt_pkg::CountW'(adt_pkg::MaxEntries))
    else $error("entry count above capacity");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.status == adt_pkg::ST_ADDED) |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the list by one");

  a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (en && res.status == adt_pkg::ST_REMOVED) |=> (count_r == $past(count_r) - 1'b1))
    else $error("remove did not shrink the list by one");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(count_r))
    else $error("entry count changed without a word");

  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> (store_r[count_r[adt_pkg::IdxW-1:0]] == '0))
    else $error("slot past the end of the list is not empty");
`endif

endmodule

// ----- rtl/core/address_set_dedup_table.sv -----
`timescale 1ns / 1ps

// Channel | Direction | Contents
// in_     | slave     | tuser: operation; tdata: station_address, slot_index
// out_    | master    | tuser: status; tdata: touched_slot, entry_count
//
// An accepted word is held in the input register; the table compare and
// compaction run from the input register straight into the result register.
// One word is accepted per cycle while the result side keeps taking words.
// A stalled result holds the input register; the input side stalls only when both are full.
// Reset clears the table, the count and both valid flags.

module address_set_dedup_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // station_address [47:0], slot_index [52:48], zero [55:53]
  input  logic        in_tuser,   // operation [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // touched_slot [4:0], entry_count [9:5], zero [15:10]
  output logic [2:0]  out_tuser   // status [2:0]
);

  logic              in_valid_r;
  adt_pkg::item_t    in_item_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  adt_pkg::result_t  out_res_r;
  adt_pkg::result_t  res;
  logic              move;

  assign move          = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready     = !in_valid_r || move;
  assign out_valid_nxt = move || (out_valid_r && !out_tready);

  adt_table u_table (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (move),
    .item (in_item_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r.op   <= adt_pkg::op_t'(in_tuser);
      in_item_r.addr <= in_tdata[47:0];
      in_item_r.idx  <= in_tdata[52:48];
    end
    if (move) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {6'd0, out_res_r.count, out_res_r.slot};

endmodule
